/* hw/rtl/lss_pkg.sv */
`default_nettype none

package lss_pkg;

    localparam int DEPTH  = 128;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int OCNT_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_SEARCH = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         position;
        logic [OCNT_W-1:0]        count;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/lss_req_if.sv */
`default_nettype none

interface lss_req_if
    import lss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lss_rsp_if.sv */
`default_nettype none

interface lss_rsp_if
    import lss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic [OCNT_W-1:0]       count;

    modport source (output valid, output status, output value, output position,
                    output count, input ready);
    modport sink   (input valid, input status, input value, input position,
                    input count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lifo_stack_with_search.sv */
`default_nettype none
// Push, clear, refused ops and unused codes: result registered in the cycle after accept.
// Pop and peek: the registered read of the stack memory (state S_READ), then the output register.
// Search: compares k entries from the top (k <= entry count);
// the shared comparator checks one memory word per cycle.
// Next transaction is accepted in the cycle its predecessor's result is taken.
// Synchronous active-low reset empties the stack; memory contents are not cleared.

module lifo_stack_with_search
    import lss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lss_req_if.sink   i_req,
    lss_rsp_if.source o_rsp
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [KEY_W-1:0]   r_rdata;
    logic [KEY_W-1:0]   r_mem [DEPTH];

    logic               w_free;
    logic               w_accept;
    logic               w_load;
    logic               w_we;
    logic [ADDR_W-1:0]  w_raddr;
    logic [CNT_W-1:0]   w_count_dec;
    logic [ADDR_W-1:0]  w_idx_dec;
    logic               w_empty;
    logic               w_full;
    t_result            w_result;

    assign i_req.ready = (r_state == S_IDLE) && w_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_count_dec = r_count - CNT_W'(1);
    assign w_idx_dec   = r_idx - ADDR_W'(1);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_req.key[KEY_W-1:0];
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_key    = r_key;
        w_load   = 1'b0;
        w_we     = 1'b0;
        w_raddr  = w_count_dec[ADDR_W-1:0];
        w_result.status   = ST_OK;
        w_result.value    = '0;
        w_result.position = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.operation)
                        OP_PUSH: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_result.status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                w_load          = 1'b1;
                                w_result.status = ST_EMPTY;
                            end else begin
                                n_count = w_count_dec;
                                n_state = S_READ;
                            end
                        end
                        OP_PEEK: begin
                            if (w_empty) begin
                                w_load          = 1'b1;
                                w_result.status = ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            w_load  = 1'b1;
                            n_count = '0;
                        end
                        OP_SEARCH: begin
                            n_key = i_req.key[KEY_W-1:0];
                            if (w_empty) begin
                                w_load          = 1'b1;
                                w_result.status = ST_NOT_FOUND;
                            end else begin
                                n_idx   = w_count_dec[ADDR_W-1:0];
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_load         = 1'b1;
                w_result.value = VAL_W'(r_rdata);
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                w_raddr = w_idx_dec;
                if (r_rdata == r_key) begin
                    w_load            = 1'b1;
                    w_result.position = POS_W'(r_idx);
                    n_state           = S_IDLE;
                end else if (r_idx == '0) begin
                    w_load          = 1'b1;
                    w_result.status = ST_NOT_FOUND;
                    n_state         = S_IDLE;
                end else begin
                    n_idx = w_idx_dec;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_result.count = OCNT_W'(n_count);
    end

    lss_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_free   (w_free),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire

/* hw/rtl/lss_out_reg.sv */
`default_nettype none

module lss_out_reg
    import lss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    lss_rsp_if.source    o_rsp
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_free         = !r_valid || o_rsp.ready;
    assign o_rsp.valid    = r_valid;
    assign o_rsp.status   = r_result.status;
    assign o_rsp.value    = r_result.value;
    assign o_rsp.position = r_result.position;
    assign o_rsp.count    = r_result.count;

endmodule

`default_nettype wire

/* hw/rtl/lss_checker.sv */
`default_nettype none

module lss_checker
    import lss_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_valid,
    input wire logic                    i_ready,
    input wire logic [STAT_W-1:0]       i_status,
    input wire logic signed [VAL_W-1:0] i_value,
    input wire logic [POS_W-1:0]        i_position,
    input wire logic [OCNT_W-1:0]       i_count
);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_count <= OCNT_W'(DEPTH)))
        else $error("count beyond depth");

    a_refused_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status != ST_OK)) |-> ((i_value == '0) && (i_position == '0)))
        else $error("refused transaction carries data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_FULL)) |-> (i_count == OCNT_W'(DEPTH)))
        else $error("full refusal with stack not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_EMPTY)) |-> (i_count == '0))
        else $error("empty refusal with stack not empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_value)
                                   && $stable(i_position) && $stable(i_count)))
        else $error("stalled result changed");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_rsp.valid),
    .i_ready    (o_rsp.ready),
    .i_status   (o_rsp.status),
    .i_value    (o_rsp.value),
    .i_position (o_rsp.position),
    .i_count    (o_rsp.count)
);

`default_nettype wire
